// ----- rtl/core/ttv_pkg.sv -----
// Shared types, constants and sequencer codes of the triangle tangent block.
`default_nettype none

package ttv_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int UV_WIDTH_DEF  = 20;
    localparam int FRAC_BITS     = 16;
    localparam int OUT_WIDTH     = 32;
    localparam int QUO_STEPS     = 32;
    localparam int MUL_STEPS     = 3;
    localparam int STEP_W        = $clog2(QUO_STEPS);

    localparam logic [OUT_WIDTH-1:0] SAT_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] SAT_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        SEL_DET,
        SEL_X,
        SEL_Y,
        SEL_Z
    } ttv_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } ttv_state_t;

    typedef struct packed {
        logic     idle;
        logic     mul_second;
        logic     acc_load;
        logic     acc_sub;
        logic     det_capture;
        logic     num_capture;
        logic     div_step;
        logic     res_write;
        logic     done_load;
        ttv_sel_t sel;
    } ttv_ctrl_t;

    typedef struct packed {
        logic start;
        logic det_zero;
        logic out_free;
    } ttv_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ttv_ifs.sv -----
// Request channels of the triangle tangent block: corners in, tangents out.
`default_nettype none

interface ttv_corner_if import ttv_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    parameter int UV_WIDTH  = UV_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic signed [UV_WIDTH-1:0]  tex_u;
    logic signed [UV_WIDTH-1:0]  tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttv_result_if import ttv_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] tangent_x;
    logic signed [OUT_WIDTH-1:0] tangent_y;
    logic signed [OUT_WIDTH-1:0] tangent_z;
    logic                        degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ttv_ctrl.sv -----
// Sequencer that steps the shared multiplier and the serial divider.
`default_nettype none

module ttv_ctrl import ttv_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ttv_stat_t stat,
    output ttv_ctrl_t ctrl
);

    ttv_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    ttv_sel_t            sel_reg, sel_next;
    logic                mul_last;
    logic                div_last;

    assign mul_last = (step_reg == STEP_W'(MUL_STEPS - 1));
    assign div_last = (step_reg == STEP_W'(QUO_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sel_reg   <= SEL_DET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.start)
                begin
                    state_next = ST_MUL;
                    step_next  = '0;
                    sel_next   = SEL_DET;
                end
            end
            ST_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ST_PREP;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                step_next = '0;
                if (sel_reg == SEL_DET)
                begin
                    if (stat.det_zero)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        sel_next   = SEL_X;
                    end
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_STORE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                step_next = '0;
                unique case (sel_reg)
                    SEL_X:
                    begin
                        state_next = ST_MUL;
                        sel_next   = SEL_Y;
                    end
                    SEL_Y:
                    begin
                        state_next = ST_MUL;
                        sel_next   = SEL_Z;
                    end
                    SEL_Z:   state_next = ST_DONE;
                    SEL_DET: state_next = ST_DONE;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl             = '0;
        ctrl.sel         = sel_reg;
        unique case (state_reg)
            ST_IDLE:  ctrl.idle = 1'b1;
            ST_MUL:
            begin
                ctrl.mul_second = (step_reg == STEP_W'(1));
                ctrl.acc_load   = (step_reg == STEP_W'(1));
                ctrl.acc_sub    = mul_last;
            end
            ST_PREP:
            begin
                ctrl.det_capture = (sel_reg == SEL_DET);
                ctrl.num_capture = (sel_reg != SEL_DET);
            end
            ST_DIV:   ctrl.div_step  = 1'b1;
            ST_STORE: ctrl.res_write = 1'b1;
            ST_DONE:  ctrl.done_load = stat.out_free;
            default:  ctrl.idle      = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/triangle_tangent_vector.sv -----
// Top level of the per-triangle tangent block with its datapath.
`default_nettype none

// Corners are taken one request at a time; the first two of a triangle are held.
// The third starts a run on one shared signed multiplier (eight products) and one
// restoring divider that yields one quotient bit per cycle: the determinant is
// multiplied and captured, and each tangent component is multiplied, set up, divided
// and stored. The output register loads once it is free, and corners are taken again
// in the next cycle. A zero determinant ends the run with a zero tangent and the
// degenerate flag set. The serial divider sets the rate. A finished result waits in
// the output register while the next two corners come in.
module triangle_tangent_vector import ttv_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    parameter int UV_WIDTH  = UV_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ttv_corner_if.sink    corner,
    ttv_result_if.source  tangent
);

    localparam int DW  = UV_WIDTH + 1;
    localparam int PDW = POS_WIDTH + 1;
    localparam int MAW = (PDW > DW) ? PDW : DW;
    localparam int PRW = MAW + DW;
    localparam int AW  = PRW + 1;
    localparam int RW  = AW + FRAC_BITS;
    localparam int SW  = AW + QUO_STEPS - 1;

    ttv_ctrl_t ctrl;
    ttv_stat_t stat;

    logic [1:0] count_reg;
    logic       accept;

    logic signed [POS_WIDTH-1:0] held_x_reg [2];
    logic signed [POS_WIDTH-1:0] held_y_reg [2];
    logic signed [POS_WIDTH-1:0] held_z_reg [2];
    logic signed [UV_WIDTH-1:0]  held_u_reg [2];
    logic signed [UV_WIDTH-1:0]  held_v_reg [2];

    logic signed [DW-1:0]  du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PDW-1:0] dp1_x_reg, dp1_y_reg, dp1_z_reg;
    logic signed [PDW-1:0] dp2_x_reg, dp2_y_reg, dp2_z_reg;

    logic signed [MAW-1:0] op_a;
    logic signed [DW-1:0]  op_b;
    logic signed [PRW-1:0] prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [AW-1:0]         acc_mag;
    logic                  acc_neg;

    logic [AW-1:0]         det_mag_reg;
    logic                  det_neg_reg;
    logic                  degen_reg;

    logic [RW-1:0]         rem_reg;
    logic [SW-1:0]         dvs_reg;
    logic [SW-1:0]         rem_ext;
    logic [SW-1:0]         rem_diff;
    logic                  ge;
    logic [QUO_STEPS-1:0]  quo_reg;
    logic                  neg_reg;
    logic [OUT_WIDTH-1:0]  comp_val;

    logic [OUT_WIDTH-1:0]  res_x_reg, res_y_reg, res_z_reg;

    logic                  out_valid_reg;
    logic [OUT_WIDTH-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic                  out_degen_reg;

    assign corner.ready = ctrl.idle;
    assign accept       = corner.valid && corner.ready;

    assign stat.start    = accept && (count_reg == 2'd2);
    assign stat.det_zero = (acc_reg == '0);
    assign stat.out_free = !out_valid_reg || tangent.ready;

    ttv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (count_reg != 2'd2))
        begin
            held_x_reg[count_reg[0]] <= corner.pos_x;
            held_y_reg[count_reg[0]] <= corner.pos_y;
            held_z_reg[count_reg[0]] <= corner.pos_z;
            held_u_reg[count_reg[0]] <= corner.tex_u;
            held_v_reg[count_reg[0]] <= corner.tex_v;
        end
        if (stat.start)
        begin
            du1_reg   <= DW'(held_u_reg[1]) - DW'(held_u_reg[0]);
            dv1_reg   <= DW'(held_v_reg[1]) - DW'(held_v_reg[0]);
            du2_reg   <= DW'(corner.tex_u) - DW'(held_u_reg[0]);
            dv2_reg   <= DW'(corner.tex_v) - DW'(held_v_reg[0]);
            dp1_x_reg <= PDW'(held_x_reg[1]) - PDW'(held_x_reg[0]);
            dp1_y_reg <= PDW'(held_y_reg[1]) - PDW'(held_y_reg[0]);
            dp1_z_reg <= PDW'(held_z_reg[1]) - PDW'(held_z_reg[0]);
            dp2_x_reg <= PDW'(corner.pos_x) - PDW'(held_x_reg[0]);
            dp2_y_reg <= PDW'(corner.pos_y) - PDW'(held_y_reg[0]);
            dp2_z_reg <= PDW'(corner.pos_z) - PDW'(held_z_reg[0]);
        end
    end

    // The determinant pairs are du1*dv2 and dv1*du2; each component pairs
    // dp1*dv2 with dp2*dv1, and the second product is subtracted.
    always_comb
    begin
        unique case (ctrl.sel)
            SEL_DET: op_a = ctrl.mul_second ? MAW'(dv1_reg) : MAW'(du1_reg);
            SEL_X:   op_a = ctrl.mul_second ? MAW'(dp2_x_reg) : MAW'(dp1_x_reg);
            SEL_Y:   op_a = ctrl.mul_second ? MAW'(dp2_y_reg) : MAW'(dp1_y_reg);
            SEL_Z:   op_a = ctrl.mul_second ? MAW'(dp2_z_reg) : MAW'(dp1_z_reg);
            default: op_a = '0;
        endcase
        if (ctrl.sel == SEL_DET)
        begin
            op_b = ctrl.mul_second ? du2_reg : dv2_reg;
        end
        else
        begin
            op_b = ctrl.mul_second ? dv1_reg : dv2_reg;
        end
    end

    assign acc_neg = acc_reg[AW-1];
    assign acc_mag = acc_neg ? (~acc_reg + 1'b1) : acc_reg;

    assign rem_ext  = {{(SW-RW){1'b0}}, rem_reg};
    assign ge       = (rem_ext >= dvs_reg);
    assign rem_diff = rem_ext - dvs_reg;

    always_comb
    begin
        if (quo_reg[QUO_STEPS-1])
        begin
            comp_val = neg_reg ? SAT_NEG : SAT_POS;
        end
        else
        begin
            comp_val = neg_reg ? OUT_WIDTH'(~quo_reg + 1'b1) : OUT_WIDTH'(quo_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (ctrl.acc_load)
        begin
            acc_reg <= AW'(prod_reg);
        end
        else if (ctrl.acc_sub)
        begin
            acc_reg <= acc_reg - AW'(prod_reg);
        end
        if (ctrl.det_capture)
        begin
            det_mag_reg <= acc_mag;
            det_neg_reg <= acc_neg;
            degen_reg   <= stat.det_zero;
            if (stat.det_zero)
            begin
                res_x_reg <= '0;
                res_y_reg <= '0;
                res_z_reg <= '0;
            end
        end
        if (ctrl.num_capture)
        begin
            rem_reg <= {acc_mag, {FRAC_BITS{1'b0}}};
            dvs_reg <= {det_mag_reg, {(QUO_STEPS-1){1'b0}}};
            neg_reg <= acc_neg ^ det_neg_reg;
            quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_diff[RW-1:0];
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[QUO_STEPS-2:0], ge};
        end
        if (ctrl.res_write)
        begin
            unique case (ctrl.sel)
                SEL_X:   res_x_reg <= comp_val;
                SEL_Y:   res_y_reg <= comp_val;
                SEL_Z:   res_z_reg <= comp_val;
                SEL_DET: res_x_reg <= res_x_reg;
                default: res_x_reg <= res_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.done_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tangent.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done_load)
        begin
            out_x_reg     <= res_x_reg;
            out_y_reg     <= res_y_reg;
            out_z_reg     <= res_z_reg;
            out_degen_reg <= degen_reg;
        end
    end

    assign tangent.valid      = out_valid_reg;
    assign tangent.tangent_x  = out_x_reg;
    assign tangent.tangent_y  = out_y_reg;
    assign tangent.tangent_z  = out_z_reg;
    assign tangent.degenerate = out_degen_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ttv_checker.sv -----
// Port-level checks of the triangle tangent block and their binding.
`default_nettype none

module ttv_checker import ttv_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [OUT_WIDTH-1:0] out_x,
    input  logic [OUT_WIDTH-1:0] out_y,
    input  logic [OUT_WIDTH-1:0] out_z,
    input  logic                 out_degen
);

    logic [1:0] corners_reg;
    logic [1:0] owed_reg;
    logic       tri_done;
    logic       out_take;

    assign tri_done = in_valid && in_ready && (corners_reg == 2'd2);
    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corners_reg <= 2'd0;
            owed_reg    <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                corners_reg <= (corners_reg == 2'd2) ? 2'd0 : corners_reg + 2'd1;
            end
            if (tri_done && !out_take)
            begin
                owed_reg <= owed_reg + 2'd1;
            end
            else if (out_take && !tri_done)
            begin
                owed_reg <= owed_reg - 2'd1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(out_degen))
        else $error("result request changed while stalled");

    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owed_reg != 2'd0)
        else $error("result shown without a completed triangle");

    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg == 2'd0 || owed_reg == 2'd1 || owed_reg == 2'd2)
        else $error("more than two triangles outstanding");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_degen |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("degenerate result with a nonzero tangent");

endmodule

bind triangle_tangent_vector ttv_checker u_ttv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (corner.valid),
    .in_ready  (corner.ready),
    .out_valid (tangent.valid),
    .out_ready (tangent.ready),
    .out_x     (tangent.tangent_x),
    .out_y     (tangent.tangent_y),
    .out_z     (tangent.tangent_z),
    .out_degen (tangent.degenerate)
);

`default_nettype wire

// ----- sim/ttv_tangent_checker.sv -----
// Scoreboard that predicts the tangent of each completed triangle and checks the block's results.
module ttv_tangent_checker import ttv_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    ttv_corner_if corner,
    ttv_result_if tangent,
    output int    fail_count,
    output int    pending,
    output int    corners_seen,
    output int    results_seen,
    output int    degenerate_seen,
    output int    saturated_seen
);

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] x;
        logic signed [OUT_WIDTH-1:0] y;
        logic signed [OUT_WIDTH-1:0] z;
        logic                        degenerate;
    } tangent_res_t;

    tangent_res_t expected_tangents[$];

    logic [1:0]                      corners_held = '0;
    logic signed [POS_WIDTH_DEF-1:0] held_x[2];
    logic signed [POS_WIDTH_DEF-1:0] held_y[2];
    logic signed [POS_WIDTH_DEF-1:0] held_z[2];
    logic signed [UV_WIDTH_DEF-1:0]  held_u[2];
    logic signed [UV_WIDTH_DEF-1:0]  held_v[2];

    // The quotient is truncated toward zero and then clamped to the output range.
    function automatic logic signed [OUT_WIDTH-1:0] tangent_component(
        wide_t dp1, wide_t dp2, wide_t dv1, wide_t dv2, wide_t det);
        wide_t        num;
        logic [127:0] num_mag;
        logic [127:0] det_mag;
        logic [127:0] quo;
        logic         negative;
        num      = dp1 * dv2 - dp2 * dv1;
        negative = num[127] ^ det[127];
        num_mag  = num[127] ? -num : num;
        det_mag  = det[127] ? -det : det;
        quo      = (num_mag << FRAC_BITS) / det_mag;
        if (negative)
            return (quo > 128'h8000_0000) ? SAT_NEG : -quo[OUT_WIDTH-1:0];
        return (quo > 128'h7fff_ffff) ? SAT_POS : quo[OUT_WIDTH-1:0];
    endfunction

    function automatic tangent_res_t triangle_tangent(
        logic signed [POS_WIDTH_DEF-1:0] px,
        logic signed [POS_WIDTH_DEF-1:0] py,
        logic signed [POS_WIDTH_DEF-1:0] pz,
        logic signed [UV_WIDTH_DEF-1:0]  u,
        logic signed [UV_WIDTH_DEF-1:0]  v);
        wide_t        du1, dv1, du2, dv2, det;
        wide_t        dx1, dx2, dy1, dy2, dz1, dz2;
        tangent_res_t res;
        du1 = held_u[1] - held_u[0];
        dv1 = held_v[1] - held_v[0];
        du2 = u - held_u[0];
        dv2 = v - held_v[0];
        dx1 = held_x[1] - held_x[0];
        dx2 = px - held_x[0];
        dy1 = held_y[1] - held_y[0];
        dy2 = py - held_y[0];
        dz1 = held_z[1] - held_z[0];
        dz2 = pz - held_z[0];
        det = du1 * dv2 - dv1 * du2;
        res.degenerate = (det == 0);
        if (det == 0)
        begin
            res.x = '0;
            res.y = '0;
            res.z = '0;
        end
        else
        begin
            res.x = tangent_component(dx1, dx2, dv1, dv2, det);
            res.y = tangent_component(dy1, dy2, dv1, dv2, det);
            res.z = tangent_component(dz1, dz2, dv1, dv2, det);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tangent_res_t got;
        tangent_res_t want;
        tangent_res_t next_want;
        if (!rst_n)
        begin
            expected_tangents.delete();
            corners_held = '0;
            for (int i = 0; i < 2; i++)
            begin
                held_x[i] = '0;
                held_y[i] = '0;
                held_z[i] = '0;
                held_u[i] = '0;
                held_v[i] = '0;
            end
            pending = 0;
        end
        else
        begin
            if (tangent.valid && tangent.ready)
            begin
                got.x          = tangent.tangent_x;
                got.y          = tangent.tangent_y;
                got.z          = tangent.tangent_z;
                got.degenerate = tangent.degenerate;
                results_seen++;
                if (got.degenerate === 1'b1)
                    degenerate_seen++;
                else if (got.x == SAT_POS || got.x == SAT_NEG || got.y == SAT_POS
                         || got.y == SAT_NEG || got.z == SAT_POS || got.z == SAT_NEG)
                    saturated_seen++;
                if (expected_tangents.size() == 0)
                begin
                    $error("tangent result with no triangle outstanding: x=%0d y=%0d z=%0d",
                           got.x, got.y, got.z);
                    fail_count++;
                end
                else
                begin
                    want = expected_tangents.pop_front();
                    if (got.x !== want.x)
                    begin
                        $error("tangent_x mismatch: expected %0d, actual %0d", want.x, got.x);
                        fail_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("tangent_y mismatch: expected %0d, actual %0d", want.y, got.y);
                        fail_count++;
                    end
                    if (got.z !== want.z)
                    begin
                        $error("tangent_z mismatch: expected %0d, actual %0d", want.z, got.z);
                        fail_count++;
                    end
                    if (got.degenerate !== want.degenerate)
                    begin
                        $error("degenerate mismatch: expected %0b, actual %0b",
                               want.degenerate, got.degenerate);
                        fail_count++;
                    end
                end
            end
            if (corner.valid && corner.ready)
            begin
                corners_seen++;
                if (corners_held == 2'd2)
                begin
                    next_want = triangle_tangent(corner.pos_x, corner.pos_y, corner.pos_z,
                                                 corner.tex_u, corner.tex_v);
                    expected_tangents = {expected_tangents, next_want};
                    corners_held = '0;
                end
                else
                begin
                    held_x[corners_held[0]] = corner.pos_x;
                    held_y[corners_held[0]] = corner.pos_y;
                    held_z[corners_held[0]] = corner.pos_z;
                    held_u[corners_held[0]] = corner.tex_u;
                    held_v[corners_held[0]] = corner.tex_v;
                    corners_held++;
                end
            end
            pending = expected_tangents.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: drives corner requests, throttles the result channel and reports the verdict.
module tb_top;
    import ttv_pkg::*;

    localparam int LONG_HOLD        = 600;
    localparam int DRAIN_CYCLES     = 150;
    localparam int RANDOM_TRIANGLES = 275;
    localparam int P_MAX            = 32'sh7fff_ffff;
    localparam int P_MIN            = 32'sh8000_0000;
    localparam int U_MAX            = 524287;
    localparam int U_MIN            = -524288;
    localparam int ONE              = 65536;

    typedef struct {
        int x;
        int y;
        int z;
        int u;
        int v;
    } corner_req_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    typedef enum int {
        SHAPE_FULL,
        SHAPE_MODERATE,
        SHAPE_THIN_UV,
        SHAPE_FLAT_UV,
        SHAPE_EXTREME_POS,
        SHAPE_TINY_SPAN
    } tri_shape_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   burst_left = 0;
    int   hold_epoch = 0;
    int   fail_count;
    int   pending;
    int   corners_seen;
    int   results_seen;
    int   degenerate_seen;
    int   saturated_seen;

    ttv_corner_if corner_ch();
    ttv_result_if tangent_ch();

    triangle_tangent_vector uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .corner  (corner_ch),
        .tangent (tangent_ch)
    );

    ttv_tangent_checker tangent_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .corner          (corner_ch),
        .tangent         (tangent_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .corners_seen    (corners_seen),
        .results_seen    (results_seen),
        .degenerate_seen (degenerate_seen),
        .saturated_seen  (saturated_seen)
    );

    always #1 clk = ~clk;

    initial begin
        #2_000_000;
        $display("triangle_tangent_vector test failed");
        $finish;
    end

    function automatic corner_req_t corner_req(int x, int y, int z, int u, int v);
        corner_req_t c;
        c.x = x;
        c.y = y;
        c.z = z;
        c.u = u;
        c.v = v;
        return c;
    endfunction

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int edge_pos();
        case ($urandom_range(0, 3))
            0: return P_MIN;
            1: return P_MAX;
            2: return 0;
            default: return int'($urandom());
        endcase
    endfunction

    task automatic send_corner(corner_req_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 150);
                default: gap = $urandom_range(1, 20);
            endcase
            if (gap > 0) begin
                corner_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        corner_ch.valid <= 1'b1;
        corner_ch.pos_x <= c.x[POS_WIDTH_DEF-1:0];
        corner_ch.pos_y <= c.y[POS_WIDTH_DEF-1:0];
        corner_ch.pos_z <= c.z[POS_WIDTH_DEF-1:0];
        corner_ch.tex_u <= c.u[UV_WIDTH_DEF-1:0];
        corner_ch.tex_v <= c.v[UV_WIDTH_DEF-1:0];
        @(posedge clk);
        while (!corner_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic send_random_triangle();
        corner_req_t c[3];
        tri_shape_t  shape;
        int          pick, base_u, base_v, du, dv, bx, by, bz, m;
        pick   = $urandom_range(0, 9);
        shape  = pick < 4 ? SHAPE_FULL : pick < 6 ? SHAPE_MODERATE : pick == 6 ? SHAPE_THIN_UV :
                 pick == 7 ? SHAPE_FLAT_UV : pick == 8 ? SHAPE_EXTREME_POS : SHAPE_TINY_SPAN;
        base_u = spread(1 << 17);
        base_v = spread(1 << 17);
        du     = ($urandom_range(0, 1) == 0) ? 0 : spread(1000);
        dv     = spread(1000);
        bx     = int'($urandom());
        by     = int'($urandom());
        bz     = int'($urandom());
        for (int i = 0; i < 3; i++) begin
            c[i] = corner_req(int'($urandom()), int'($urandom()), int'($urandom()),
                              int'($urandom()), int'($urandom()));
            case (shape)
                SHAPE_MODERATE: begin
                    c[i].x = spread(1 << 20);
                    c[i].y = spread(1 << 20);
                    c[i].z = spread(1 << 20);
                    c[i].u = spread(1 << 17);
                    c[i].v = spread(1 << 17);
                end
                SHAPE_THIN_UV: begin
                    c[i].u = base_u + spread(4);
                    c[i].v = base_v + spread(4);
                end
                SHAPE_FLAT_UV: begin
                    // Collinear texture coordinates give a zero determinant.
                    m = spread(3);
                    c[i].u = base_u + m * du;
                    c[i].v = base_v + m * (du == 0 ? 0 : dv);
                end
                SHAPE_EXTREME_POS: begin
                    c[i].x = edge_pos();
                    c[i].y = edge_pos();
                    c[i].z = edge_pos();
                    c[i].u = base_u + spread(64);
                    c[i].v = base_v + spread(64);
                end
                SHAPE_TINY_SPAN: begin
                    c[i].x = bx + spread(2);
                    c[i].y = by + spread(2);
                    c[i].z = bz + spread(2);
                end
                default: ;
            endcase
        end
        for (int i = 0; i < 3; i++)
            send_corner(c[i]);
    endtask

    initial begin
        rx_mode_t mode;
        int       seen_epoch;
        int       hold_left;
        int       seg_left;
        mode       = RX_OPEN;
        seen_epoch = 0;
        hold_left  = 0;
        seg_left   = 0;
        tangent_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (seg_left == 0) begin
                mode     = rx_mode_t'($urandom_range(0, 2));
                seg_left = $urandom_range(1, 64);
            end
            seg_left--;
            if (hold_epoch != seen_epoch) begin
                seen_epoch = hold_epoch;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                tangent_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   tangent_ch.ready <= 1'b1;
                    RX_RANDOM: tangent_ch.ready <= ($urandom_range(0, 1) == 1);
                    default:   tangent_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        corner_ch.valid <= 1'b0;
        corner_ch.pos_x <= '0;
        corner_ch.pos_y <= '0;
        corner_ch.pos_z <= '0;
        corner_ch.tex_u <= '0;
        corner_ch.tex_v <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // All three corners share one texture coordinate.
        send_corner(corner_req(P_MIN, P_MAX, 0, U_MAX, U_MIN));
        send_corner(corner_req(P_MAX, P_MIN, ONE, U_MAX, U_MIN));
        send_corner(corner_req(0, 0, P_MIN, U_MAX, U_MIN));
        // A unit triangle whose tangent is exactly one along x.
        send_corner(corner_req(0, 0, 0, 0, 0));
        send_corner(corner_req(ONE, 0, 0, ONE, 0));
        send_corner(corner_req(0, ONE, 0, 0, ONE));
        // Position extremes saturate in both directions.
        send_corner(corner_req(P_MIN, P_MAX, P_MIN, 0, 0));
        send_corner(corner_req(P_MAX, P_MIN, P_MAX, ONE, 0));
        send_corner(corner_req(P_MIN, P_MAX, P_MIN, 0, ONE));
        // Texture coordinate extremes.
        send_corner(corner_req(ONE, -ONE, 3, U_MIN, U_MIN));
        send_corner(corner_req(2 * ONE, 5, -7, U_MAX, U_MIN));
        send_corner(corner_req(-ONE, ONE, 0, U_MIN, U_MAX));
        // Collinear texture coordinates.
        send_corner(corner_req(1, 2, 3, 0, 0));
        send_corner(corner_req(4, 5, 6, ONE, ONE));
        send_corner(corner_req(7, 8, 9, 2 * ONE, 2 * ONE));
        // The smallest nonzero determinant against large position deltas.
        send_corner(corner_req(0, 0, 0, 0, 0));
        send_corner(corner_req(P_MAX, P_MIN, 1000, 1, 0));
        send_corner(corner_req(P_MIN, P_MAX, -1000, 0, 1));
        // Small negative quotients truncate toward zero.
        send_corner(corner_req(0, 0, 0, 0, 0));
        send_corner(corner_req(-1, 1, -1, U_MAX, 0));
        send_corner(corner_req(0, 0, 0, 0, U_MAX));
        // Texture coordinates on one line give a zero determinant and a degenerate result.
        send_corner(corner_req(ONE, 2 * ONE, 3 * ONE, ONE, ONE));
        send_corner(corner_req(-5 * ONE, 7, P_MAX, 0, 3 * ONE));
        send_corner(corner_req(12345, -ONE, P_MIN, 2 * ONE, -ONE));

        hold_epoch++;
        for (int t = 0; t < RANDOM_TRIANGLES; t++) begin
            if (t == RANDOM_TRIANGLES / 2)
                hold_epoch++;
            send_random_triangle();
        end
        corner_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d corner requests and checked %0d tangents, %0d degenerate and %0d saturated.",
                 corners_seen, results_seen, degenerate_seen, saturated_seen);
        $display("The result channel was held off twice for %0d cycles under load.", LONG_HOLD);
        if (fail_count == 0)
            $display("triangle_tangent_vector test passed");
        else
            $display("triangle_tangent_vector test failed");
        $finish;
    end

endmodule

// ----- triangle_tangent_vector.f -----
rtl/core/ttv_pkg.sv
rtl/core/ttv_ifs.sv
rtl/core/ttv_ctrl.sv
rtl/core/triangle_tangent_vector.sv
rtl/core/ttv_checker.sv
sim/ttv_tangent_checker.sv
sim/tb_top.sv
